// ----- hdl/polyline_arc_length_locator_core_macros.svh -----
// Assertion macros shared by the polyline locator RTL.
`ifndef POLYLINE_ARC_LENGTH_LOCATOR_CORE_MACROS_SVH
`define POLYLINE_ARC_LENGTH_LOCATOR_CORE_MACROS_SVH
// Implication in the same cycle.
`define PALC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palc assertion failed");
// Implication in the following cycle.
`define PALC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("palc assertion failed");
`endif

// ----- hdl/palc_pkg.sv -----
// Package with types and constants of the polyline locator.
`default_nettype none
package palc_pkg;
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam int ACC_W      = 68;
   localparam int SQ_LAST    = 32;
   localparam int ROOT_LAST  = 33;
   localparam int FRAC_LAST  = 15;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] query_distance;
   } palc_req_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         segment_index;
      logic [15:0]        fraction;
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
   } palc_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH0, S_PREV, S_CUR, S_SQX, S_SQY, S_ROOT,
      S_CMP, S_NEXT, S_DIV, S_MULX, S_MULY, S_DONE
   } palc_state_type;
endpackage
`default_nettype wire

// ----- hdl/palc_if.sv -----
// Request and response channel interfaces of the polyline locator.
`default_nettype none
interface palc_req_if;
   import palc_pkg::*;
   logic         valid;
   logic         ready;
   palc_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface palc_rsp_if;
   import palc_pkg::*;
   logic         valid;
   logic         ready;
   palc_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/palc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module palc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/polyline_arc_length_locator_core.sv -----
// Top level of the polyline arc-length locator.
// Clear and append requests are handled in S_IDLE; the block is ready again next cycle.
// Query: fetch vertex 0 (S_FETCH0, S_PREV); per segment set up, square dx and dy, take the root,
// compare and, if passed, fetch the next vertex; on a hit divide, interpolate x and y, then load rsp.
// Throughput is one request at a time; req ready is low while a query runs or waits on rsp.
// Synchronous active-high reset empties the store; vertex RAM content is not cleared.
`default_nettype none
`include "polyline_arc_length_locator_core_macros.svh"
module polyline_arc_length_locator_core #(
   parameter int MAX_POINTS = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   palc_req_if.sink    req_chan,
   palc_rsp_if.source  rsp_chan
);
   import palc_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   palc_state_type state_ff, state_in;

   // Store fill level and walk index (index of the segment end vertex).
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;

   // Walk datapath.
   logic [31:0]        dist_ff, dist_in;    // remaining distance, never negative
   logic [31:0]        prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [ACC_W-1:0]   acc_ff, acc_in, mcand_ff, mcand_in;
   logic [32:0]        mplier_ff, mplier_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [35:0]        rem_ff, rem_in;
   logic [33:0]        root_ff, root_in;
   logic [15:0]        frac_ff, frac_in;
   logic [31:0]        px_ff, px_in, py_ff, py_in;
   logic               found_ff, found_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   palc_rsp_type rsp_data_ff, rsp_data_in;

   // RAM ports.
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rdx, rdy;

   // Shared compare/subtract and accumulate units.
   logic [35:0]      sub_a, sub_b;
   logic [36:0]      diff;
   logic             ge;
   logic [ACC_W-1:0] acc_sum;

   logic               req_fire, count_lt2, last_step;
   logic signed [32:0] dx_c, dy_c;
   logic [32:0]        abs_dx_c, abs_dy_ff;
   logic [CW-1:0]      seg_full;
   logic [CW+7:0]      seg_wide;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign count_lt2 = count_ff < CW'(2);
   assign wr_en     = req_fire && (req_chan.data.opcode == OP_APPEND)
                      && (count_ff < CW'(MAX_POINTS));
   // Vertex 0 is fetched first; afterwards the end vertex of the current segment.
   assign rd_addr   = (state_ff == S_FETCH0) ? AW'(0) : idx_ff[AW-1:0];

   palc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_chan.data.vertex_x), .rd_addr(rd_addr), .rd_data(rdx)
   );
   palc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_chan.data.vertex_y), .rd_addr(rd_addr), .rd_data(rdy)
   );

   assign dx_c      = $signed({rdx[31], rdx}) - $signed({prevx_ff[31], prevx_ff});
   assign dy_c      = $signed({rdy[31], rdy}) - $signed({prevy_ff[31], prevy_ff});
   assign abs_dx_c  = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
   assign abs_dy_ff = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);

   // Shared shift-add accumulate: add the multiplicand when the multiplier LSB is set.
   assign acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   // Shared subtractor operands: root trial, distance compare or division step.
   always_comb begin
      case (state_ff)
         S_ROOT: begin
            sub_a = {rem_ff[33:0], acc_ff[ACC_W-1 -: 2]};
            sub_b = {root_ff, 2'b01};
         end
         S_CMP: begin
            sub_a = {4'd0, dist_ff};
            sub_b = {2'd0, root_ff};
         end
         S_DIV: begin
            sub_a = {rem_ff[34:0], 1'b0};
            sub_b = {2'd0, root_ff};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end
   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = !diff[36];

   assign last_step = ((state_ff == S_SQX || state_ff == S_SQY) && cnt_ff == 6'(SQ_LAST))
                   || (state_ff == S_ROOT && cnt_ff == 6'(ROOT_LAST))
                   || ((state_ff == S_DIV || state_ff == S_MULX || state_ff == S_MULY)
                       && cnt_ff == 6'(FRAC_LAST));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.data.opcode == OP_QUERY) begin
               if (count_lt2 || req_chan.data.query_distance[31]) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FETCH0;
               end
            end
         end
         S_FETCH0: state_in = S_PREV;
         S_PREV:   state_in = S_CUR;
         S_CUR:    state_in = S_SQX;
         S_SQX:    if (last_step) state_in = S_SQY;
         S_SQY:    if (last_step) state_in = S_ROOT;
         S_ROOT:   if (last_step) state_in = S_CMP;
         S_CMP: begin
            if (!ge) begin
               state_in = S_DIV;
            end else if (idx_ff + CW'(1) == count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_NEXT:   state_in = S_CUR;
         S_DIV:    if (last_step) state_in = S_MULX;
         S_MULX:   if (last_step) state_in = S_MULY;
         S_MULY:   if (last_step) state_in = S_DONE;
         S_DONE:   if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   assign seg_full = idx_ff - CW'(1);
   assign seg_wide = {8'd0, seg_full};

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      dist_in      = dist_ff;
      prevx_in     = prevx_ff;
      prevy_in     = prevy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff + 6'd1;
      rem_in       = rem_ff;
      root_in      = root_ff;
      frac_in      = frac_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.data.opcode)
                  OP_CLEAR:  count_in = '0;
                  OP_APPEND: if (wr_en) count_in = count_ff + CW'(1);
                  OP_QUERY: begin
                     idx_in   = CW'(1);
                     dist_in  = req_chan.data.query_distance;
                     found_in = 1'b0;
                     frac_in  = '0;
                     px_in    = '0;
                     py_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_PREV: begin
            prevx_in = rdx;
            prevy_in = rdy;
         end
         S_CUR: begin
            // Start dx^2 with vertex idx against the held start vertex.
            dx_in     = dx_c;
            dy_in     = dy_c;
            acc_in    = '0;
            mcand_in  = ACC_W'(abs_dx_c);
            mplier_in = abs_dx_c;
            cnt_in    = '0;
         end
         S_SQX, S_SQY: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[32:1]};
            if (last_step) begin
               cnt_in = '0;
               if (state_ff == S_SQX) begin
                  mcand_in  = ACC_W'(abs_dy_ff);
                  mplier_in = abs_dy_ff;
               end else begin
                  rem_in  = '0;
                  root_in = '0;
               end
            end
         end
         S_ROOT: begin
            // Two radicand bits per step; restoring square root.
            acc_in  = {acc_ff[ACC_W-3:0], 2'b00};
            rem_in  = ge ? diff[35:0] : sub_a;
            root_in = {root_ff[32:0], ge};
         end
         S_CMP: begin
            if (ge) begin
               // Distance lies beyond this segment: consume its length and advance.
               dist_in  = diff[31:0];
               idx_in   = idx_ff + CW'(1);
               prevx_in = rdx;
               prevy_in = rdy;
            end else begin
               rem_in  = {4'd0, dist_ff};
               frac_in = '0;
               cnt_in  = '0;
            end
         end
         S_DIV: begin
            rem_in  = ge ? diff[35:0] : sub_a;
            frac_in = {frac_ff[14:0], ge};
            if (last_step) begin
               cnt_in    = '0;
               acc_in    = '0;
               mcand_in  = ACC_W'(dx_ff);
               mplier_in = {17'd0, frac_ff[14:0], ge};
            end
         end
         S_MULX, S_MULY: begin
            acc_in    = acc_sum;
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[32:1]};
            if (last_step) begin
               cnt_in = '0;
               if (state_ff == S_MULX) begin
                  px_in     = prevx_ff + acc_sum[47:16];
                  acc_in    = '0;
                  mcand_in  = ACC_W'(dy_ff);
                  mplier_in = {17'd0, frac_ff};
               end else begin
                  py_in    = prevy_ff + acc_sum[47:16];
                  found_in = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.found         = found_ff;
               rsp_data_in.segment_index = found_ff ? seg_wide[7:0] : 8'd0;
               rsp_data_in.fraction      = frac_ff;
               rsp_data_in.position_x    = px_ff;
               rsp_data_in.position_y    = py_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      dist_ff     <= dist_in;
      prevx_ff    <= prevx_in;
      prevy_ff    <= prevy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      frac_ff     <= frac_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   `PALC_ASSERT_NOW(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_chan.ready)
   `PALC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_POINTS))
   `PALC_ASSERT_NOW(a_walk_in_store, clock, reset, state_ff == S_CMP, idx_ff < count_ff)
   `PALC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.found,
      rsp_data_ff.fraction == 16'd0 && rsp_data_ff.position_x == 32'sd0)
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the polyline arc-length locator: queued stimulus, predictor, checker.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import palc_pkg::*;

   localparam int DEPTH       = 256;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int TAIL_CYCLES = 60;

   logic clock;
   logic reset;

   palc_req_if req_chan ();
   palc_rsp_if rsp_chan ();

   polyline_arc_length_locator_core #(.MAX_POINTS(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor copy of the vertex store.
   logic signed [31:0] model_x [DEPTH];
   logic signed [31:0] model_y [DEPTH];
   int                 model_count;

   palc_req_type pending_reqs [$];
   palc_rsp_type expected_points [$];

   int  error_count;
   int  accepted_reqs;
   int  accepted_queries;
   int  hold_left;
   bit  hold_done;
   int  cycle_count;

   // Stimulus builder's own view of the polyline, used to pick distances.
   logic signed [31:0] gen_x [$];
   logic signed [31:0] gen_y [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // floor(sqrt(dx^2 + dy^2)) in raw units.
   function automatic logic [63:0] seg_length(logic signed [63:0] dx, logic signed [63:0] dy);
      logic [63:0]  adx;
      logic [63:0]  ady;
      logic [127:0] sq;
      logic [127:0] p;
      logic [63:0]  root;
      logic [63:0]  t;
      adx  = dx < 0 ? -dx : dx;
      ady  = dy < 0 ? -dy : dy;
      sq   = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         t = root | (64'd1 << b);
         p = {64'd0, t} * {64'd0, t};
         if (p <= sq) root = t;
      end
      return root;
   endfunction

   // Walk the stored segments and locate the point at the given arc length.
   function automatic palc_rsp_type predict_arc_point(logic signed [31:0] arc_len);
      palc_rsp_type       r;
      logic signed [63:0] d;
      logic signed [63:0] x0;
      logic signed [63:0] y0;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0]        len;
      logic [63:0]        frac;
      logic signed [63:0] px;
      logic signed [63:0] py;
      r = '0;
      d = arc_len;
      if (model_count < 2 || d < 0) return r;
      for (int i = 1; i < model_count; i++) begin
         x0  = model_x[i-1];
         y0  = model_y[i-1];
         dx  = 64'(signed'(model_x[i])) - x0;
         dy  = 64'(signed'(model_y[i])) - y0;
         len = seg_length(dx, dy);
         // A zero-length segment never holds the point and subtracts nothing.
         if (64'(d) < len) begin
            frac = (64'(d) << 16) / len;
            px   = x0 + ((dx * signed'(frac)) >>> 16);
            py   = y0 + ((dy * signed'(frac)) >>> 16);
            r.found         = 1'b1;
            r.segment_index = 8'(i - 1);
            r.fraction      = frac[15:0];
            r.position_x    = px[31:0];
            r.position_y    = py[31:0];
            return r;
         end
         d = d - signed'(len);
      end
      return r;
   endfunction

   // Advance the predictor with one accepted request.
   task automatic apply_request(palc_req_type rq);
      case (rq.opcode)
         OP_CLEAR: model_count = 0;
         OP_APPEND: begin
            // Drop appends to a full store.
            if (model_count < DEPTH) begin
               model_x[model_count] = rq.vertex_x;
               model_y[model_count] = rq.vertex_y;
               model_count++;
            end
         end
         OP_QUERY: expected_points = {expected_points, predict_arc_point(rq.query_distance)};
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Queue a request with random filler in the fields the opcode ignores.
   task automatic push_req(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] q);
      palc_req_type rq;
      rq.opcode         = op;
      rq.vertex_x       = x;
      rq.vertex_y       = y;
      rq.query_distance = q;
      pending_reqs = {pending_reqs, rq};
      case (op)
         OP_CLEAR: begin
            gen_x.delete();
            gen_y.delete();
         end
         OP_APPEND: if (gen_x.size() < DEPTH) begin
            gen_x = {gen_x, x};
            gen_y = {gen_y, y};
         end
         default: ;
      endcase
   endtask

   function automatic logic [63:0] gen_total();
      logic [63:0] total;
      total = 0;
      for (int i = 1; i < gen_x.size(); i++)
         total += seg_length(64'(signed'(gen_x[i])) - 64'(signed'(gen_x[i-1])),
                             64'(signed'(gen_y[i])) - 64'(signed'(gen_y[i-1])));
      return total;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'h8000_0000;
         2:       return 32'h7fff_ffff;
         3:       return 32'(signed'($urandom_range(0, 8)) - 4);
         default: return 32'(signed'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      endcase
   endfunction

   // Pick a distance that lands on, at the end of, or off the current polyline.
   function automatic logic [31:0] rand_distance();
      logic [63:0] total;
      total = gen_total();
      if (total > 64'h7fff_ffff) total = 64'h7fff_ffff;
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'h8000_0000 | $urandom();
         2:       return total[31:0];
         3:       return total == 0 ? 32'd0 : 32'(total - 1);
         4:       return 32'd0;
         default: return total == 0 ? 32'd0 : 32'($urandom() % total);
      endcase
   endfunction

   function automatic bit idle_roll();
      // Hold the line busy over a long stretch of the run.
      if (accepted_reqs >= 250 && accepted_reqs < 340) return 1'b0;
      return $urandom_range(0, 99) < 15;
   endfunction

   // Driver: offer queued requests, update the predictor on each handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_request(req_chan.data);
            accepted_reqs++;
            if (req_chan.data.opcode == OP_QUERY) accepted_queries++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_reqs.size() > 0 && !idle_roll()) begin
               req_chan.valid <= 1'b1;
               req_chan.data  <= pending_reqs.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once, so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_queries >= 40) begin
         hold_left <= 3000;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check each accepted response against the oldest prediction.
   always @(posedge clock) begin
      palc_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               $display("unexpected response at cycle %0d", cycle_count);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_chan.data.found !== want.found)
                  report_mismatch("found", rsp_chan.data.found, want.found);
               if (rsp_chan.data.segment_index !== want.segment_index)
                  report_mismatch("segment_index", rsp_chan.data.segment_index,
                                  want.segment_index);
               if (rsp_chan.data.fraction !== want.fraction)
                  report_mismatch("fraction", rsp_chan.data.fraction, want.fraction);
               if (rsp_chan.data.position_x !== want.position_x)
                  report_mismatch("position_x", rsp_chan.data.position_x, want.position_x);
               if (rsp_chan.data.position_y !== want.position_y)
                  report_mismatch("position_y", rsp_chan.data.position_y, want.position_y);
            end
         end
         rsp_chan.ready <= (hold_left == 0) && !idle_roll();
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int n;
      int q;
      error_count      = 0;
      accepted_reqs    = 0;
      accepted_queries = 0;
      cycle_count      = 0;
      model_count      = 0;
      req_chan.valid   = 1'b0;
      req_chan.data    = '0;
      rsp_chan.ready   = 1'b0;
      reset            = 1'b1;

      // Directed: empty and single-point store, zero-length segment, negative distance, exact total, unknown opcode.
      push_req(OP_QUERY, $urandom(), $urandom(), 32'd0);
      push_req(OP_APPEND, 32'd0, 32'd0, $urandom());
      push_req(OP_QUERY, $urandom(), $urandom(), 32'd0);
      push_req(OP_APPEND, 32'h0003_0000, 32'h0004_0000, $urandom());
      push_req(OP_APPEND, 32'h0003_0000, 32'h0004_0000, $urandom()); // zero-length
      push_req(OP_APPEND, 32'hfffd_0000, 32'h0004_0000, $urandom());
      push_req(OP_QUERY, $urandom(), $urandom(), 32'hffff_ffff);
      push_req(OP_QUERY, $urandom(), $urandom(), 32'h0000_8000);
      push_req(OP_QUERY, $urandom(), $urandom(), 32'h0005_0000);
      push_req(OP_QUERY, $urandom(), $urandom(), 32'(gen_total()));
      push_req(OP_QUERY, $urandom(), $urandom(), 32'(gen_total() - 1));
      push_req(2'd3, $urandom(), $urandom(), $urandom());
      push_req(OP_QUERY, $urandom(), $urandom(), 32'h7fff_ffff);
      // Extreme corners.
      push_req(OP_CLEAR, $urandom(), $urandom(), $urandom());
      push_req(OP_APPEND, 32'h8000_0000, 32'h8000_0000, $urandom());
      push_req(OP_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, $urandom());
      push_req(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, $urandom());
      push_req(OP_QUERY, $urandom(), $urandom(), 32'h7fff_ffff);
      push_req(OP_QUERY, $urandom(), $urandom(), 32'h1234_5678);
      push_req(OP_QUERY, $urandom(), $urandom(), 32'h8000_0000);
      // Fill the store, then one extra append that must be dropped.
      push_req(OP_CLEAR, $urandom(), $urandom(), $urandom());
      for (int i = 0; i <= DEPTH; i++)
         push_req(OP_APPEND, 32'(i * 32'h0001_0000), 32'(signed'($urandom_range(0, 255)) - 128),
                  $urandom());
      push_req(OP_QUERY, $urandom(), $urandom(), 32'(gen_total() - 1));
      push_req(OP_QUERY, $urandom(), $urandom(), 32'(gen_total()));

      // Random: mostly well-formed build-then-query sequences, some noise.
      while (pending_reqs.size() < 580) begin
         if ($urandom_range(0, 99) < 85) begin
            push_req(OP_CLEAR, $urandom(), $urandom(), $urandom());
            n = $urandom_range(0, 19) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 8);
            for (int i = 0; i < n; i++)
               push_req(OP_APPEND, rand_coord(), rand_coord(), $urandom());
            q = $urandom_range(1, 6);
            for (int i = 0; i < q; i++)
               push_req(OP_QUERY, $urandom(), $urandom(), rand_distance());
         end else begin
            case ($urandom_range(0, 3))
               0: push_req(OP_CLEAR, $urandom(), $urandom(), $urandom());
               1: if (gen_x.size() < 12) push_req(OP_APPEND, rand_coord(), rand_coord(),
                                                  $urandom());
               2: push_req(OP_QUERY, $urandom(), $urandom(), rand_distance());
               default: push_req(2'd3, $urandom(), $urandom(), $urandom());
            endcase
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for the queue to drain and every response to come back.
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_chan.valid || expected_points.size() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_points.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
